FILE: hdl/ncl_pkg.sv
// Shared types and constants for the nearest-center leader clustering block.
package ncl_pkg;

    localparam int MAX_CENTERS = 256;
    localparam int IDX_W       = $clog2(MAX_CENTERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 16;
    localparam int RAD_W       = 15;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int ENTRY_W     = 2 * COORD_W;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(768);

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [IDX_W-1:0]          read_index;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]          active_index;
        logic                      active_changed;
        logic                      center_created;
        logic                      table_full;
        logic [CNT_W-1:0]          center_count;
        logic signed [COORD_W-1:0] read_x;
        logic signed [COORD_W-1:0] read_y;
        logic                      read_valid;
    } t_rsp;

endpackage

FILE: hdl/ncl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ncl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/nearest_center_leader_clustering.sv
// Top level: center table, nearest-center scan sequencer and result register.
//
//  channel   | signals                        | direction | transfer
//  ----------+--------------------------------+-----------+-------------------------------
//  command   | start, busy, i_cmd             | in        | start high while busy low
//  result    | o_done, o_rsp                  | out       | o_done high, one cycle, no stall
//  config    | i_cfg_we, i_cfg_wdata          | in        | i_cfg_we high (cell radius)
//
// Steps: an update over N stored centers first squares 2*radius, then runs
// square-x, square-y and compare per center on the one shared multiplier, then a
// finish step strobes the result.
// Empty-table update, clear, append and read go straight to the finish step.
// Reset zeroes the count and active index and loads radius 768; no store clear.
// Receiver cannot stall; busy falls with the strobe, so a new command may transfer then.
module nearest_center_leader_clustering (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ncl_pkg::t_cmd               i_cmd,
    output logic                        o_done,
    output ncl_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ncl_pkg::RAD_W-1:0]   i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIM,   // square 2*radius into the limit register
        S_SQX,   // square dx of the current center
        S_SQY,   // square dy of the current center
        S_CMP,   // sum and compare against best, advance index
        S_FIN    // finish the command, append or read, drive result
    } t_state;

    // state and registered outputs
    t_state                          r_state, n_state;
    ncl_pkg::t_cmd                   r_cmd, n_cmd;
    logic [ncl_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [ncl_pkg::IDX_W-1:0]       r_best_idx, n_best_idx;
    logic [ncl_pkg::DIST_W-1:0]      r_best, n_best;
    logic [ncl_pkg::SQ_W-1:0]        r_lim, n_lim;
    logic [ncl_pkg::SQ_W-1:0]        r_sqx, n_sqx;
    logic [ncl_pkg::SQ_W-1:0]        r_sqy, n_sqy;
    logic [ncl_pkg::CNT_W-1:0]       r_count, n_count;
    logic [ncl_pkg::IDX_W-1:0]       r_active, n_active;
    logic [ncl_pkg::RAD_W-1:0]       r_radius, n_radius;
    logic                            r_done, n_done;
    ncl_pkg::t_rsp                   r_rsp, n_rsp;

    // shared squaring unit
    logic signed [ncl_pkg::DIFF_W-1:0]   mul_op;
    logic signed [2*ncl_pkg::DIFF_W-1:0] mul_prod;
    logic [ncl_pkg::SQ_W-1:0]            sq;

    // center store
    logic                             ram_we;
    logic [ncl_pkg::ENTRY_W-1:0]      ram_rdata;
    logic signed [ncl_pkg::COORD_W-1:0] cen_x, cen_y;
    logic signed [ncl_pkg::DIFF_W-1:0]  dx, dy;
    logic [ncl_pkg::DIST_W-1:0]         dist_sum;
    logic                               accept;
    logic                               need;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign cen_x = ram_rdata[ncl_pkg::ENTRY_W-1:ncl_pkg::COORD_W];
    assign cen_y = ram_rdata[ncl_pkg::COORD_W-1:0];
    assign dx = ncl_pkg::DIFF_W'(cen_x) - ncl_pkg::DIFF_W'(r_cmd.pos_x);
    assign dy = ncl_pkg::DIFF_W'(cen_y) - ncl_pkg::DIFF_W'(r_cmd.pos_y);

    always_comb begin
        case (r_state)
            S_LIM:   mul_op = $signed(ncl_pkg::DIFF_W'({r_radius, 1'b0}));
            S_SQY:   mul_op = dy;
            default: mul_op = dx;
        endcase
    end

    assign mul_prod = mul_op * mul_op;
    assign sq       = mul_prod[ncl_pkg::SQ_W-1:0];   // square of |op| < 2^16 fits
    assign dist_sum = ncl_pkg::DIST_W'(r_sqx) + ncl_pkg::DIST_W'(r_sqy);

    // read address follows the next index, so data in a state is mem[r_idx]
    ncl_ram #(
        .WIDTH (ncl_pkg::ENTRY_W),
        .DEPTH (ncl_pkg::MAX_CENTERS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ncl_pkg::IDX_W-1:0]),
        .i_wdata ({r_cmd.pos_x, r_cmd.pos_y}),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_lim      = r_lim;
        n_sqx      = r_sqx;
        n_sqy      = r_sqy;
        n_count    = r_count;
        n_active   = r_active;
        n_radius   = i_cfg_we ? i_cfg_wdata : r_radius;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        ram_we     = 1'b0;
        need       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = i_cmd;
                    n_best_idx = '0;
                    n_idx      = (i_cmd.op == ncl_pkg::OP_READ) ? i_cmd.read_index : '0;
                    if (i_cmd.op == ncl_pkg::OP_UPDATE && r_count != '0) begin
                        n_state = S_LIM;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LIM: begin
                n_lim   = sq;
                n_state = S_SQX;
            end
            S_SQX: begin
                n_sqx   = sq;
                n_state = S_SQY;
            end
            S_SQY: begin
                n_sqy   = sq;
                n_state = S_CMP;
            end
            S_CMP: begin
                // strict less keeps the lowest index on a tie
                if (r_idx == '0 || dist_sum < r_best) begin
                    n_best     = dist_sum;
                    n_best_idx = r_idx;
                end
                if (ncl_pkg::CNT_W'(r_idx) + ncl_pkg::CNT_W'(1) < r_count) begin
                    n_idx   = r_idx + ncl_pkg::IDX_W'(1);
                    n_state = S_SQX;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_rsp = '0;
                case (r_cmd.op)
                    ncl_pkg::OP_UPDATE: begin
                        n_active = (r_count == '0) ? '0 : r_best_idx;
                        need     = (r_count == '0) ||
                                   (ncl_pkg::DIST_W'(r_lim) < r_best);
                        n_rsp.active_changed = (n_active != r_active);
                    end
                    ncl_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    ncl_pkg::OP_APPEND: begin
                        need = 1'b1;
                    end
                    default: begin
                        if (ncl_pkg::CNT_W'(r_cmd.read_index) < r_count) begin
                            n_rsp.read_valid = 1'b1;
                            n_rsp.read_x     = cen_x;
                            n_rsp.read_y     = cen_y;
                        end
                    end
                endcase
                if (need) begin
                    if (r_count < ncl_pkg::CNT_W'(ncl_pkg::MAX_CENTERS)) begin
                        ram_we               = 1'b1;
                        n_count              = r_count + ncl_pkg::CNT_W'(1);
                        n_rsp.center_created = 1'b1;
                    end else begin
                        n_rsp.table_full = 1'b1;
                    end
                end
                n_rsp.active_index = n_active;
                n_rsp.center_count = n_count;
                n_done             = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmd      <= '0;
            r_idx      <= '0;
            r_best_idx <= '0;
            r_best     <= '0;
            r_lim      <= '0;
            r_sqx      <= '0;
            r_sqy      <= '0;
            r_count    <= '0;
            r_active   <= '0;
            r_radius   <= ncl_pkg::RADIUS_RESET;
            r_done     <= 1'b0;
            r_rsp      <= '0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_idx      <= n_idx;
            r_best_idx <= n_best_idx;
            r_best     <= n_best;
            r_lim      <= n_lim;
            r_sqx      <= n_sqx;
            r_sqy      <= n_sqy;
            r_count    <= n_count;
            r_active   <= n_active;
            r_radius   <= n_radius;
            r_done     <= n_done;
            r_rsp      <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // the strobe only follows the finish step, which returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ncl_pkg::CNT_W'(ncl_pkg::MAX_CENTERS))
        else $error("center count beyond table size");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQX) |-> (ncl_pkg::CNT_W'(r_idx) < r_count))
        else $error("scan index beyond stored centers");

    a_created_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_rsp.center_created && r_rsp.table_full))
        else $error("append both done and refused");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command transfer did not start the sequencer");

endmodule
